// ----- rtl/avc_pkg.sv -----
// Shared types and constants of the AVC configuration record parser.
// No dependencies; imported by every module of the block.
package avc_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] PROFILE_HIGH    = 8'd100;
    localparam logic [7:0] PROFILE_HIGH10  = 8'd110;
    localparam logic [7:0] PROFILE_HIGH422 = 8'd122;
    localparam logic [7:0] PROFILE_HIGH444 = 8'd144;

    localparam logic [1:0] LIST_SPS = 2'd0;
    localparam logic [1:0] LIST_PPS = 2'd1;
    localparam logic [1:0] LIST_EXT = 2'd2;

    typedef enum logic [4:0] {
        PH_VERSION     = 5'd0,
        PH_PROFILE     = 5'd1,
        PH_COMPAT      = 5'd2,
        PH_LEVEL       = 5'd3,
        PH_LENSIZE     = 5'd4,
        PH_SPSCOUNT    = 5'd5,
        PH_LENHI       = 5'd6,
        PH_LENLO       = 5'd7,
        PH_PAYLOAD     = 5'd8,
        PH_PPSCOUNT    = 5'd10,
        PH_CHROMA      = 5'd11,
        PH_LUMADEPTH   = 5'd12,
        PH_CHROMADEPTH = 5'd13,
        PH_EXTCOUNT    = 5'd14,
        PH_DONE        = 5'd15
    } t_phase;

    typedef enum logic [4:0] {
        KIND_VERSION     = 5'd0,
        KIND_PROFILE     = 5'd1,
        KIND_COMPAT      = 5'd2,
        KIND_LEVEL       = 5'd3,
        KIND_LENSIZE     = 5'd4,
        KIND_SPSCOUNT    = 5'd5,
        KIND_LENHI       = 5'd6,
        KIND_LENLO       = 5'd7,
        KIND_PAYLOAD     = 5'd8,
        KIND_ZERORUN     = 5'd9,
        KIND_PPSCOUNT    = 5'd10,
        KIND_CHROMA      = 5'd11,
        KIND_LUMADEPTH   = 5'd12,
        KIND_CHROMADEPTH = 5'd13,
        KIND_EXTCOUNT    = 5'd14,
        KIND_IGNORED     = 5'd15,
        KIND_STARTCODE   = 5'd16
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] field_value;
        logic [1:0]  array_kind;
        logic [7:0]  unit_index;
        logic        unit_end;
        logic        record_done;
        logic        truncated;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    item0;
        t_result    item1;
    } t_push;

endpackage

// ----- rtl/avc_cfg_parse.sv -----
// Parser state and per-byte decode: up to two result transactions per byte.
// Depends on avc_pkg.
module avc_cfg_parse (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  logic [7:0]     i_data_byte,
    input  logic           i_end_of_record,
    output avc_pkg::t_push o_push
);
    import avc_pkg::*;

    t_phase      r_phase,        n_phase;
    logic [7:0]  r_profile,      n_profile;
    logic [7:0]  r_units_left,   n_units_left;
    logic [7:0]  r_unit_number,  n_unit_number;
    logic [15:0] r_bytes_left,   n_bytes_left;
    logic [7:0]  r_length_high,  n_length_high;
    logic [15:0] r_held_zeros,   n_held_zeros;
    logic        r_prefix_check, n_prefix_check;
    logic [1:0]  r_current_list, n_current_list;

    logic        w_eor;
    logic        w_last;
    logic        w_ext;
    logic [15:0] w_len;
    logic [15:0] w_held_inc;
    logic [7:0]  w_units_dec;
    logic [1:0]  w_count;
    t_result     w_item0;
    t_result     w_item1;
    logic        w_done;

    function automatic t_phase f_start_units(input logic [7:0] units, input logic [1:0] list,
                                             input logic ext, input logic eor);
        t_phase ph;
        if (units != 8'd0)
            ph = PH_LENHI;
        else if (list == LIST_SPS)
            ph = PH_PPSCOUNT;
        else if (list == LIST_PPS && ext && !eor)
            ph = PH_CHROMA;
        else
            ph = PH_DONE;
        return ph;
    endfunction

    function automatic t_result f_item(input t_kind kind, input logic [15:0] value,
                                       input logic [1:0] list, input logic [7:0] idx,
                                       input logic uend);
        t_result r;
        r.kind        = kind;
        r.field_value = value;
        r.array_kind  = list;
        r.unit_index  = idx;
        r.unit_end    = uend;
        r.record_done = 1'b0;
        r.truncated   = 1'b0;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    assign w_eor       = i_end_of_record;
    assign w_last      = r_bytes_left <= 16'd1;
    assign w_ext       = r_profile == PROFILE_HIGH || r_profile == PROFILE_HIGH10 ||
                         r_profile == PROFILE_HIGH422 || r_profile == PROFILE_HIGH444;
    assign w_len       = {r_length_high, i_data_byte};
    assign w_held_inc  = 16'(r_held_zeros + 16'd1);
    assign w_units_dec = 8'(r_units_left - 8'd1);

    always_comb begin
        n_phase        = r_phase;
        n_profile      = r_profile;
        n_units_left   = r_units_left;
        n_unit_number  = r_unit_number;
        n_bytes_left   = r_bytes_left;
        n_length_high  = r_length_high;
        n_held_zeros   = r_held_zeros;
        n_prefix_check = r_prefix_check;
        n_current_list = r_current_list;
        unique case (r_phase)
            PH_VERSION:     n_phase = PH_PROFILE;
            PH_PROFILE: begin
                n_profile = i_data_byte;
                n_phase   = PH_COMPAT;
            end
            PH_COMPAT:      n_phase = PH_LEVEL;
            PH_LEVEL:       n_phase = PH_LENSIZE;
            PH_LENSIZE:     n_phase = PH_SPSCOUNT;
            PH_SPSCOUNT: begin
                n_current_list = LIST_SPS;
                n_units_left   = {3'b000, i_data_byte[4:0]};
                n_unit_number  = 8'd0;
                n_phase        = f_start_units(n_units_left, LIST_SPS, w_ext, w_eor);
            end
            PH_LENHI: begin
                n_length_high = i_data_byte;
                n_phase       = PH_LENLO;
            end
            PH_LENLO: begin
                n_bytes_left   = w_len;
                n_held_zeros   = 16'd0;
                n_prefix_check = 1'b1;
                if (w_len == 16'd0) begin
                    n_units_left  = w_units_dec;
                    n_unit_number = 8'(r_unit_number + 8'd1);
                    n_phase       = f_start_units(w_units_dec, r_current_list, w_ext, w_eor);
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_bytes_left = w_last ? 16'd0 : 16'(r_bytes_left - 16'd1);
                if (r_prefix_check) begin
                    if (i_data_byte == 8'd0 && !w_last) begin
                        n_held_zeros = w_held_inc;
                    end else begin
                        n_held_zeros   = 16'd0;
                        n_prefix_check = 1'b0;
                    end
                end
                if (w_last) begin
                    n_units_left  = w_units_dec;
                    n_unit_number = 8'(r_unit_number + 8'd1);
                    n_phase       = f_start_units(w_units_dec, r_current_list, w_ext, w_eor);
                end
            end
            PH_PPSCOUNT: begin
                n_current_list = LIST_PPS;
                n_units_left   = i_data_byte;
                n_unit_number  = 8'd0;
                n_phase        = f_start_units(i_data_byte, LIST_PPS, w_ext, w_eor);
            end
            PH_CHROMA:      n_phase = PH_LUMADEPTH;
            PH_LUMADEPTH:   n_phase = PH_CHROMADEPTH;
            PH_CHROMADEPTH: n_phase = PH_EXTCOUNT;
            PH_EXTCOUNT: begin
                n_current_list = LIST_EXT;
                n_units_left   = i_data_byte;
                n_unit_number  = 8'd0;
                n_phase        = f_start_units(i_data_byte, LIST_EXT, w_ext, w_eor);
            end
            default:        n_phase = PH_DONE;
        endcase
    end

    always_comb begin
        w_count = 2'd1;
        w_item0 = f_item(KIND_IGNORED, {8'd0, i_data_byte}, LIST_SPS, 8'd0, 1'b0);
        w_item1 = w_item0;
        unique case (r_phase)
            PH_VERSION:
                w_item0 = f_item(KIND_VERSION, {8'd0, i_data_byte}, LIST_SPS, 8'd0, 1'b0);
            PH_PROFILE:
                w_item0 = f_item(KIND_PROFILE, {8'd0, i_data_byte}, LIST_SPS, 8'd0, 1'b0);
            PH_COMPAT:
                w_item0 = f_item(KIND_COMPAT, {8'd0, i_data_byte}, LIST_SPS, 8'd0, 1'b0);
            PH_LEVEL:
                w_item0 = f_item(KIND_LEVEL, {8'd0, i_data_byte}, LIST_SPS, 8'd0, 1'b0);
            PH_LENSIZE:
                w_item0 = f_item(KIND_LENSIZE, {14'd0, i_data_byte[1:0]}, LIST_SPS, 8'd0,
                                 1'b0);
            PH_SPSCOUNT:
                w_item0 = f_item(KIND_SPSCOUNT, {11'd0, i_data_byte[4:0]}, LIST_SPS, 8'd0,
                                 1'b0);
            PH_LENHI:
                w_item0 = f_item(KIND_LENHI, {8'd0, i_data_byte}, r_current_list,
                                 r_unit_number, 1'b0);
            PH_LENLO:
                w_item0 = f_item(KIND_LENLO, w_len, r_current_list, r_unit_number,
                                 w_len == 16'd0);
            PH_PAYLOAD: begin
                if (!r_prefix_check) begin
                    w_item0 = f_item(KIND_PAYLOAD, {8'd0, i_data_byte}, r_current_list,
                                     r_unit_number, w_last);
                end else if (i_data_byte == 8'd0 && !w_last) begin
                    w_count = w_eor ? 2'd1 : 2'd0;
                    w_item0 = f_item(KIND_ZERORUN, w_held_inc, r_current_list,
                                     r_unit_number, 1'b0);
                end else if (i_data_byte == 8'd0) begin
                    w_item0 = f_item(KIND_ZERORUN, w_held_inc, r_current_list,
                                     r_unit_number, 1'b1);
                end else if (i_data_byte == 8'd1 && r_held_zeros >= 16'd2) begin
                    w_item0 = f_item(KIND_STARTCODE, w_held_inc, r_current_list,
                                     r_unit_number, w_last);
                end else if (r_held_zeros != 16'd0) begin
                    w_count = 2'd2;
                    w_item0 = f_item(KIND_ZERORUN, r_held_zeros, r_current_list,
                                     r_unit_number, 1'b0);
                    w_item1 = f_item(KIND_PAYLOAD, {8'd0, i_data_byte}, r_current_list,
                                     r_unit_number, w_last);
                end else begin
                    w_item0 = f_item(KIND_PAYLOAD, {8'd0, i_data_byte}, r_current_list,
                                     r_unit_number, w_last);
                end
            end
            PH_PPSCOUNT:
                w_item0 = f_item(KIND_PPSCOUNT, {8'd0, i_data_byte}, LIST_SPS, 8'd0, 1'b0);
            PH_CHROMA:
                w_item0 = f_item(KIND_CHROMA, {14'd0, i_data_byte[1:0]}, LIST_SPS, 8'd0,
                                 1'b0);
            PH_LUMADEPTH:
                w_item0 = f_item(KIND_LUMADEPTH, {13'd0, i_data_byte[2:0]}, LIST_SPS, 8'd0,
                                 1'b0);
            PH_CHROMADEPTH:
                w_item0 = f_item(KIND_CHROMADEPTH, {13'd0, i_data_byte[2:0]}, LIST_SPS,
                                 8'd0, 1'b0);
            PH_EXTCOUNT:
                w_item0 = f_item(KIND_EXTCOUNT, {8'd0, i_data_byte}, LIST_SPS, 8'd0, 1'b0);
            default:
                w_item0 = f_item(KIND_IGNORED, {8'd0, i_data_byte}, LIST_SPS, 8'd0, 1'b0);
        endcase
        w_done = n_phase == PH_DONE;
        if (w_count == 2'd2) begin
            w_item1.record_done = w_done;
            w_item1.truncated   = w_eor && !w_done;
            w_item1.last_of_run = 1'b1;
        end else begin
            w_item0.record_done = w_done;
            w_item0.truncated   = w_eor && !w_done;
            w_item0.last_of_run = 1'b1;
        end
    end

    always_comb begin
        o_push.count = i_step ? w_count : 2'd0;
        o_push.item0 = w_item0;
        o_push.item1 = w_item1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && w_eor)) begin
            r_phase        <= PH_VERSION;
            r_profile      <= 8'd0;
            r_units_left   <= 8'd0;
            r_unit_number  <= 8'd0;
            r_bytes_left   <= 16'd0;
            r_length_high  <= 8'd0;
            r_held_zeros   <= 16'd0;
            r_prefix_check <= 1'b0;
            r_current_list <= LIST_SPS;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_profile      <= n_profile;
            r_units_left   <= n_units_left;
            r_unit_number  <= n_unit_number;
            r_bytes_left   <= n_bytes_left;
            r_length_high  <= n_length_high;
            r_held_zeros   <= n_held_zeros;
            r_prefix_check <= n_prefix_check;
            r_current_list <= n_current_list;
        end
    end

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.count == 2'd2 |-> o_push.item0.kind == KIND_ZERORUN &&
                                 o_push.item1.kind == KIND_PAYLOAD)
        else $error("two-result byte not a zero run then payload");

    a_eor_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_end_of_record |=> r_phase == PH_VERSION && r_prefix_check == 1'b0)
        else $error("record end did not restart the parse");

    a_silent_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_push.count == 2'd0 |-> r_phase == PH_PAYLOAD && r_prefix_check &&
                                            !i_end_of_record)
        else $error("byte dropped outside a held zero");

endmodule

// ----- rtl/avc_cfg_queue.sv -----
// Result queue: takes up to two result transactions per cycle, issues one.
// Depends on avc_pkg.
module avc_cfg_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  avc_pkg::t_push                  i_push,
    input  logic                            i_pop,
    output avc_pkg::t_result                o_head,
    output logic [avc_pkg::Q_CNT_W-1:0]     o_count
);
    import avc_pkg::*;

    t_result              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count,  n_count;
    logic [Q_PTR_W-1:0]   w_wr_next;

    assign w_wr_next = Q_PTR_W'(r_wr_ptr + 1'b1);
    assign n_wr_ptr  = Q_PTR_W'(r_wr_ptr + Q_PTR_W'(i_push.count));
    assign n_rd_ptr  = i_pop ? Q_PTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
    assign n_count   = Q_CNT_W'(r_count + Q_CNT_W'(i_push.count) - Q_CNT_W'(i_pop));
    assign o_head    = r_mem[r_rd_ptr];
    assign o_count   = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0)
            r_mem[r_wr_ptr] <= i_push.item0;
        if (i_push.count == 2'd2)
            r_mem[w_wr_next] <= i_push.item1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- rtl/avc_config_record_parser.sv -----
// Top level of the AVC decoder configuration record parser.
// Depends on avc_pkg, avc_cfg_parse and avc_cfg_queue.
//
// Accepts one record byte per cycle while not stalled and emits tagged result
// transactions from a four-entry result queue. A byte passes an input
// register, is decoded combinationally against the parser state and lands in
// the queue. Most bytes yield one result; a byte that ends a run of held
// leading zeros without forming a start code yields two, and a held zero
// yields none unless it ends the record. The input register is held while
// fewer than two queue entries are free, so sustained throughput is one byte
// per cycle limited only by the output taking one result per cycle. A byte with
// end_of_record set returns the parser to its reset state after its results.
module avc_config_record_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_record,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_kind,
    output logic [15:0] o_field_value,
    output logic [1:0]  o_array_kind,
    output logic [7:0]  o_unit_index,
    output logic        o_unit_end,
    output logic        o_record_done,
    output logic        o_truncated,
    output logic        o_last_of_run
);
    import avc_pkg::*;

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_eor;
    logic               w_room;
    logic               w_step;
    logic               w_pop;
    logic [Q_CNT_W-1:0] w_count;
    t_push              w_push;
    t_result            w_head;

    assign w_room     = w_count <= Q_CNT_W'(Q_DEPTH - 2);
    assign w_step     = r_in_valid && w_room;
    assign o_in_stall = r_in_valid && !w_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_in_valid <= 1'b0;
        else if (!o_in_stall)
            r_in_valid <= i_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_data_byte;
            r_in_eor  <= i_end_of_record;
        end
    end

    avc_cfg_parse u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_data_byte     (r_in_byte),
        .i_end_of_record (r_in_eor),
        .o_push          (w_push)
    );

    avc_cfg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_count (w_count)
    );

    assign o_out_valid   = w_count != '0;
    assign w_pop         = o_out_valid && !i_out_stall;
    assign o_kind        = w_head.kind;
    assign o_field_value = w_head.field_value;
    assign o_array_kind  = w_head.array_kind;
    assign o_unit_index  = w_head.unit_index;
    assign o_unit_end    = w_head.unit_end;
    assign o_record_done = w_head.record_done;
    assign o_truncated   = w_head.truncated;
    assign o_last_of_run = w_head.last_of_run;

endmodule
